// ===== src/spi_flash_command_sequencer_assert.svh =====
// assertion macros used by the sequencer top file
`ifndef SPI_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// property checked on every clock edge outside reset
`define SFCS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every clock edge outside reset
`define SFCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/sfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcs_pkg
// types, codes and defaults shared by the spi flash command sequencer
// ----------------------------------------------------------------------------
package sfcs_pkg;

  localparam int unsigned BlockBytesDef   = 4096;
  localparam int unsigned PageBytesDef    = 256;
  localparam int unsigned ProgBufBytesDef = 256;
  localparam int unsigned VerifyFrameDef  = 32;

  localparam logic [15:0] ReadWaitRst  = 16'd13;
  localparam logic [15:0] WriteWaitRst = 16'd250;

  localparam logic [7:0] FL_WREN  = 8'h06;
  localparam logic [7:0] FL_RDSR  = 8'h05;
  localparam logic [7:0] FL_PP    = 8'h02;
  localparam logic [7:0] FL_SE    = 8'h20;
  localparam logic [7:0] FL_READ  = 8'h03;
  localparam logic [7:0] FL_DUMMY = 8'hFF;

  // input word codes
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_PROG  = 3'd1;
  localparam logic [2:0] CMD_ERASE = 3'd2;
  localparam logic [2:0] CMD_DATA  = 3'd3;
  localparam logic [2:0] CMD_RX    = 3'd4;
  localparam logic [2:0] CMD_TICK  = 3'd5;

  // configuration register indexes
  localparam logic [0:0] CFG_READ_WAIT  = 1'b0;
  localparam logic [0:0] CFG_WRITE_WAIT = 1'b1;

  // completion status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_IO      = 2'd2;
  localparam logic [1:0] ST_CORRUPT = 2'd3;

  typedef enum logic [1:0] {
    OP_READ, OP_PROG, OP_ERASE, OP_VERIFY
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_COLLECT, PH_POLL_CMD, PH_POLL_STAT, PH_POLL_TICK, PH_WEN,
    PH_WEL_CMD, PH_WEL_STAT, PH_H1, PH_H2, PH_H3, PH_H4, PH_DATA
  } phase_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_release;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

// ===== src/spi_flash_command_sequencer.sv =====
// a result word is offered on out_ the cycle after its input word is taken if the
// output queue is empty; throughput: one input word per cycle while the queue is
// not full, set by the combinational sequencer update and the prefetching two-port
// buffer ram; a two-word output queue keeps input flowing while a result waits
// reset: synchronous active low, clears control state; the buffer ram is not cleared
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer
// spi nor flash read, program and erase sequencer with busy polling and verify
// ----------------------------------------------------------------------------
`include "spi_flash_command_sequencer_assert.svh"
module spi_flash_command_sequencer import sfcs_pkg::*; #(
  parameter int unsigned BLOCK_BYTES    = BlockBytesDef,
  parameter int unsigned PAGE_BYTES     = PageBytesDef,
  parameter int unsigned PROG_BUF_BYTES = ProgBufBytesDef,
  parameter int unsigned VERIFY_FRAME   = VerifyFrameDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [9:0]  in_block_index,
  input  logic [11:0] in_offset,
  input  logic [12:0] in_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_cs_release,
  output logic        out_rd_valid,
  output logic [7:0]  out_rd_byte,
  output logic        out_done_res,
  output logic [1:0]  out_status
);

  localparam int unsigned IW = $clog2(PROG_BUF_BYTES);

  logic [15:0] read_wait_r, write_wait_r;
  logic          acc, we, res_valid, push, pop;
  logic [IW-1:0] waddr, raddr_a, raddr_b;
  logic [7:0]    wdata, rdata_a, rdata_b;
  res_t          res;
  res_t          q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_wait_r  <= ReadWaitRst;
      write_wait_r <= WriteWaitRst;
    end else if (cfg_we) begin
      if (cfg_index == CFG_READ_WAIT) begin
        read_wait_r <= cfg_wdata;
      end
      if (cfg_index == CFG_WRITE_WAIT) begin
        write_wait_r <= cfg_wdata;
      end
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign acc      = in_valid && in_ready;

  sfcs_seq #(
    .BLOCK_BYTES(BLOCK_BYTES), .PAGE_BYTES(PAGE_BYTES),
    .PROG_BUF_BYTES(PROG_BUF_BYTES), .VERIFY_FRAME(VERIFY_FRAME)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .acc(acc), .cmd(in_cmd),
    .block_index(in_block_index), .offset(in_offset), .length(in_length),
    .data_byte(in_data_byte), .read_wait(read_wait_r), .write_wait(write_wait_r),
    .rdata_a(rdata_a), .rdata_b(rdata_b), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .res_valid(res_valid), .res(res)
  );

  sfcs_store #(.DEPTH(PROG_BUF_BYTES)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rdata_a), .rdata_b(rdata_b)
  );

  // two-word output queue
  assign push = res_valid;
  assign pop  = out_valid && out_ready;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          q0_nxt = res;
        end else begin
          q1_nxt = res;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        q0_nxt  = q1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          q0_nxt = res;
        end else begin
          q0_nxt = q1_r;
          q1_nxt = res;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_tx_valid   = q0_r.tx_valid;
  assign out_tx_byte    = q0_r.tx_byte;
  assign out_cs_release = q0_r.cs_release;
  assign out_rd_valid   = q0_r.rd_valid;
  assign out_rd_byte    = q0_r.rd_byte;
  assign out_done_res   = q0_r.done_res;
  assign out_status     = q0_r.status;

  // checks
  `SFCS_ASSERT_CLK(a_cnt_range, cnt_r != 2'd3, "output queue count out of range")
  `SFCS_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty queue")
  `SFCS_ASSERT_IMP(a_done_no_tx, out_valid && out_done_res, !out_tx_valid,
                   "completion word also carries a transmit byte")

endmodule

// ===== src/sfcs_store.sv =====
// ----------------------------------------------------------------------------
// sfcs_store
// program buffer ram, one write port and two registered read ports with
// write-to-read forwarding
// ----------------------------------------------------------------------------
module sfcs_store import sfcs_pkg::*; #(
  parameter int unsigned DEPTH = ProgBufBytesDef
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [7:0]               rdata_a,
  output logic [7:0]               rdata_b
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, a same-cycle write is passed straight through
  always_ff @(posedge clk) begin
    rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
  end

endmodule

// ===== src/sfcs_seq.sv =====
// ----------------------------------------------------------------------------
// sfcs_seq
// command sequencer: frame state, busy polling and buffer addressing
// ----------------------------------------------------------------------------
module sfcs_seq import sfcs_pkg::*; #(
  parameter int unsigned BLOCK_BYTES    = BlockBytesDef,
  parameter int unsigned PAGE_BYTES     = PageBytesDef,
  parameter int unsigned PROG_BUF_BYTES = ProgBufBytesDef,
  parameter int unsigned VERIFY_FRAME   = VerifyFrameDef,
  localparam int unsigned IW = $clog2(PROG_BUF_BYTES),
  localparam int unsigned BW = $clog2(PROG_BUF_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [2:0]    cmd,
  input  logic [9:0]    block_index,
  input  logic [11:0]   offset,
  input  logic [12:0]   length,
  input  logic [7:0]    data_byte,
  input  logic [15:0]   read_wait,
  input  logic [15:0]   write_wait,
  input  logic [7:0]    rdata_a,
  input  logic [7:0]    rdata_b,
  output logic          we,
  output logic [IW-1:0] waddr,
  output logic [7:0]    wdata,
  output logic [IW-1:0] raddr_a,
  output logic [IW-1:0] raddr_b,
  output logic          res_valid,
  output res_t          res
);

  localparam logic [12:0] ProgBufLen  = 13'(PROG_BUF_BYTES);
  localparam logic [12:0] VerifyLen   = 13'(VERIFY_FRAME);
  localparam logic [23:0] PageMask    = 24'(PAGE_BYTES - 1);
  localparam logic [24:0] PageLen     = 25'(PAGE_BYTES);
  localparam logic [23:0] BlockLen    = 24'(BLOCK_BYTES);

  phase_t      phase_r, phase_nxt;
  op_t         op_r, op_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [12:0] left_r, left_nxt;
  logic [12:0] frame_r, frame_nxt;
  logic [BW-1:0] bp_r, bp_nxt, bp_inc;
  logic [15:0] wait_r, wait_nxt;
  logic        bad_r, bad_nxt;

  logic [23:0] cur_a;
  logic [24:0] page_room;
  logic [12:0] frame_w;
  logic [15:0] limit;
  logic [15:0] wait_inc;
  logic [23:0] blk_base;

  function automatic logic [IW-1:0] buf_idx(input logic [BW-1:0] p);
    logic [IW-1:0] r;
    r = (32'(p) < PROG_BUF_BYTES) ? IW'(p) : '0;
    return r;
  endfunction

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= OP_READ;
      addr_r  <= '0;
      left_r  <= '0;
      frame_r <= '0;
      bp_r    <= '0;
      wait_r  <= '0;
      bad_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      frame_r <= frame_nxt;
      bp_r    <= bp_nxt;
      wait_r  <= wait_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // prefetch buffer entries at the next position and the one after
  assign raddr_a = buf_idx(bp_nxt);
  assign raddr_b = buf_idx(bp_nxt + BW'(1));

  // next state and result word
  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    frame_nxt = frame_r;
    bp_nxt    = bp_r;
    wait_nxt  = wait_r;
    bad_nxt   = bad_r;
    res_valid = 1'b0;
    res       = '0;
    we        = 1'b0;
    waddr     = buf_idx(bp_r);
    wdata     = data_byte;
    cur_a     = addr_r + 24'(bp_r);
    page_room = PageLen - 25'(cur_a & PageMask);
    frame_w   = '0;
    limit     = (op_r == OP_READ) ? read_wait : write_wait;
    wait_inc  = (wait_r != 16'hFFFF) ? wait_r + 16'd1 : wait_r;
    blk_base  = 24'(block_index) * BlockLen;
    bp_inc    = bp_r + BW'(1);

    if (acc) begin
      priority case (1'b1)
        // new request
        (cmd == CMD_READ || cmd == CMD_PROG || cmd == CMD_ERASE): begin
          if (phase_r == PH_IDLE) begin
            bp_nxt  = '0;
            bad_nxt = 1'b0;
            if (cmd == CMD_ERASE) begin
              op_nxt = OP_ERASE; addr_nxt = blk_base; left_nxt = 13'd1;
              wait_nxt = '0; phase_nxt = PH_POLL_CMD;
              res_valid = 1'b1; res.tx_valid = 1'b1; res.tx_byte = FL_RDSR;
            end else if (length == '0 || (cmd == CMD_PROG && length > ProgBufLen)) begin
              res_valid = 1'b1; res.done_res = 1'b1; res.status = ST_INVALID;
            end else begin
              op_nxt   = (cmd == CMD_READ) ? OP_READ : OP_PROG;
              addr_nxt = blk_base + 24'(offset);
              left_nxt = length;
              if (cmd == CMD_READ) begin
                wait_nxt = '0; phase_nxt = PH_POLL_CMD;
                res_valid = 1'b1; res.tx_valid = 1'b1; res.tx_byte = FL_RDSR;
              end else begin
                phase_nxt = PH_COLLECT;
              end
            end
          end
        end
        // program data collection
        (cmd == CMD_DATA): begin
          if (phase_r == PH_COLLECT) begin
            we = 1'b1;
            if (13'(bp_inc) < left_r) begin
              bp_nxt = bp_inc;
            end else begin
              bp_nxt = '0; wait_nxt = '0; phase_nxt = PH_POLL_CMD;
              res_valid = 1'b1; res.tx_valid = 1'b1; res.tx_byte = FL_RDSR;
            end
          end
        end
        // byte back from the shifter
        (cmd == CMD_RX): begin
          unique case (phase_r)
            PH_POLL_CMD: begin
              phase_nxt = PH_POLL_STAT; res_valid = 1'b1;
              res.tx_valid = 1'b1; res.tx_byte = FL_DUMMY; res.cs_release = 1'b1;
            end
            PH_POLL_STAT: begin
              if (data_byte[0]) begin
                phase_nxt = PH_POLL_TICK;
              end else begin
                res_valid = 1'b1;
                if (op_r == OP_READ) begin
                  phase_nxt = PH_H1; res.tx_valid = 1'b1; res.tx_byte = FL_READ;
                end else if (op_r == OP_PROG && left_r == '0) begin
                  left_nxt = 13'(bp_r); bp_nxt = '0; bad_nxt = 1'b0;
                  op_nxt = OP_VERIFY; phase_nxt = PH_H1;
                  res.tx_valid = 1'b1; res.tx_byte = FL_READ;
                end else if ((op_r == OP_PROG || op_r == OP_ERASE) && left_r != '0) begin
                  phase_nxt = PH_WEN; res.tx_valid = 1'b1; res.tx_byte = FL_WREN;
                  res.cs_release = 1'b1;
                end else begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
                end
              end
            end
            PH_WEN: begin
              phase_nxt = PH_WEL_CMD; res_valid = 1'b1;
              res.tx_valid = 1'b1; res.tx_byte = FL_RDSR;
            end
            PH_WEL_CMD: begin
              phase_nxt = PH_WEL_STAT; res_valid = 1'b1;
              res.tx_valid = 1'b1; res.tx_byte = FL_DUMMY; res.cs_release = 1'b1;
            end
            PH_WEL_STAT: begin
              res_valid = 1'b1;
              if (!data_byte[1]) begin
                phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_IO;
              end else begin
                phase_nxt = PH_H1; res.tx_valid = 1'b1;
                res.tx_byte = (op_r == OP_ERASE) ? FL_SE : FL_PP;
              end
            end
            PH_H1: begin
              phase_nxt = PH_H2; res_valid = 1'b1;
              res.tx_valid = 1'b1; res.tx_byte = cur_a[23:16];
            end
            PH_H2: begin
              phase_nxt = PH_H3; res_valid = 1'b1;
              res.tx_valid = 1'b1; res.tx_byte = cur_a[15:8];
            end
            PH_H3: begin
              phase_nxt = PH_H4; res_valid = 1'b1;
              res.tx_valid = 1'b1; res.tx_byte = cur_a[7:0];
              res.cs_release = (op_r == OP_ERASE);
            end
            PH_H4: begin
              res_valid = 1'b1; res.tx_valid = 1'b1;
              if (op_r == OP_ERASE) begin
                left_nxt = '0; wait_nxt = '0; phase_nxt = PH_POLL_CMD;
                res.tx_byte = FL_RDSR;
              end else begin
                phase_nxt = PH_DATA;
                if (op_r == OP_READ) begin
                  frame_w = left_r; res.tx_byte = FL_DUMMY;
                end else if (op_r == OP_PROG) begin
                  frame_w = (page_room > 25'(left_r)) ? left_r : 13'(page_room);
                  res.tx_byte = rdata_a;
                end else begin
                  frame_w = (left_r > VerifyLen) ? VerifyLen : left_r;
                  res.tx_byte = FL_DUMMY;
                end
                frame_nxt = frame_w;
                res.cs_release = (frame_w == 13'd1);
              end
            end
            PH_DATA: begin
              res_valid = 1'b1;
              if (op_r == OP_READ) begin
                left_nxt  = left_r - 13'd1;
                frame_nxt = left_r - 13'd1;
                res.rd_valid = 1'b1; res.rd_byte = data_byte;
                if (left_r == 13'd1) begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
                end else begin
                  res.tx_valid = 1'b1; res.tx_byte = FL_DUMMY;
                  res.cs_release = (left_r == 13'd2);
                end
              end else begin
                frame_w   = frame_r - 13'd1;
                bad_nxt   = bad_r || (op_r == OP_VERIFY && rdata_a != data_byte);
                bp_nxt    = bp_inc;
                left_nxt  = left_r - 13'd1;
                frame_nxt = frame_w;
                if (op_r == OP_PROG) begin
                  res.tx_valid = 1'b1;
                  if (frame_w != '0) begin
                    res.tx_byte = rdata_b; res.cs_release = (frame_w == 13'd1);
                  end else begin
                    wait_nxt = '0; phase_nxt = PH_POLL_CMD; res.tx_byte = FL_RDSR;
                  end
                end else if (frame_w != '0) begin
                  res.tx_valid = 1'b1; res.tx_byte = FL_DUMMY;
                  res.cs_release = (frame_w == 13'd1);
                end else if (bad_nxt) begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_CORRUPT;
                end else if (left_r == 13'd1) begin
                  phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_OK;
                end else begin
                  phase_nxt = PH_H1; res.tx_valid = 1'b1; res.tx_byte = FL_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
        // millisecond tick during busy polling
        (cmd == CMD_TICK): begin
          if (phase_r == PH_POLL_CMD || phase_r == PH_POLL_STAT ||
              phase_r == PH_POLL_TICK) begin
            wait_nxt = wait_inc;
            if (phase_r == PH_POLL_TICK) begin
              res_valid = 1'b1;
              if (wait_inc >= limit) begin
                phase_nxt = PH_IDLE; res.done_res = 1'b1; res.status = ST_IO;
              end else begin
                phase_nxt = PH_POLL_CMD; res.tx_valid = 1'b1; res.tx_byte = FL_RDSR;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sim/spi_flash_command_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_checker
// watches the word channels, predicts each result word and compares in order
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_checker import sfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [9:0]  in_block_index,
  input  logic [11:0] in_offset,
  input  logic [12:0] in_length,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_tx_valid,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_cs_release,
  input  logic        out_rd_valid,
  input  logic [7:0]  out_rd_byte,
  input  logic        out_done_res,
  input  logic [1:0]  out_status,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirrored sequencer state
  logic [15:0] rd_limit, wr_limit;
  phase_t      seq_phase;
  op_t         seq_op;
  logic [23:0] base_addr;
  logic [12:0] remaining;
  logic [12:0] in_frame;
  logic [8:0]  buf_pos;
  logic [15:0] ticks_seen;
  logic        frame_bad;
  logic [7:0]  page_data [256];

  res_t expected_words [$];

  function automatic res_t mk(logic txv, logic [7:0] txb, logic rel, logic rdv,
                              logic [7:0] rdb, logic dn, logic [1:0] st);
    res_t r;
    r.tx_valid = txv; r.tx_byte = txb; r.cs_release = rel;
    r.rd_valid = rdv; r.rd_byte = rdb; r.done_res = dn; r.status = st;
    return r;
  endfunction

  function automatic res_t shift_out(logic [7:0] b, logic rel, phase_t nxt);
    seq_phase = nxt;
    return mk(1'b1, b, rel, 1'b0, 8'h00, 1'b0, ST_OK);
  endfunction

  function automatic res_t complete(logic [1:0] st, logic rdv, logic [7:0] rdb);
    seq_phase = PH_IDLE;
    return mk(1'b0, 8'h00, 1'b0, rdv, rdb, 1'b1, st);
  endfunction

  function automatic res_t begin_poll();
    ticks_seen = '0;
    return shift_out(FL_RDSR, 1'b0, PH_POLL_CMD);
  endfunction

  // next step once the flash reports not busy
  function automatic res_t flash_ready();
    if (seq_op == OP_READ) return shift_out(FL_READ, 1'b0, PH_H1);
    if (seq_op == OP_PROG) begin
      if (remaining > 0) return shift_out(FL_WREN, 1'b1, PH_WEN);
      remaining = 13'(buf_pos);
      buf_pos   = '0;
      frame_bad = 1'b0;
      seq_op    = OP_VERIFY;
      return shift_out(FL_READ, 1'b0, PH_H1);
    end
    if (seq_op == OP_ERASE && remaining > 0) return shift_out(FL_WREN, 1'b1, PH_WEN);
    return complete(ST_OK, 1'b0, 8'h00);
  endfunction

  // reaction to a byte from the spi shifter
  task automatic take_rx(input logic [7:0] rx, output bit got, output res_t r);
    logic [23:0] a;
    logic [12:0] room;
    a   = base_addr + 24'(buf_pos);
    got = 1'b1;
    case (seq_phase)
      PH_POLL_CMD: r = shift_out(FL_DUMMY, 1'b1, PH_POLL_STAT);
      PH_POLL_STAT: begin
        if (!rx[0]) r = flash_ready();
        else begin
          seq_phase = PH_POLL_TICK;
          got = 1'b0;
        end
      end
      PH_WEN:      r = shift_out(FL_RDSR, 1'b0, PH_WEL_CMD);
      PH_WEL_CMD:  r = shift_out(FL_DUMMY, 1'b1, PH_WEL_STAT);
      PH_WEL_STAT: begin
        if (!rx[1]) r = complete(ST_IO, 1'b0, 8'h00);
        else r = shift_out(seq_op == OP_ERASE ? FL_SE : FL_PP, 1'b0, PH_H1);
      end
      PH_H1: r = shift_out(a[23:16], 1'b0, PH_H2);
      PH_H2: r = shift_out(a[15:8], 1'b0, PH_H3);
      PH_H3: r = shift_out(a[7:0], seq_op == OP_ERASE, PH_H4);
      PH_H4: begin
        if (seq_op == OP_ERASE) begin
          remaining = '0;
          r = begin_poll();
        end else if (seq_op == OP_PROG) begin
          room = 13'd256 - 13'(a[7:0]);
          in_frame = room > remaining ? remaining : room;
          r = shift_out(page_data[buf_pos[7:0]], in_frame == 1, PH_DATA);
        end else begin
          if (seq_op == OP_READ) in_frame = remaining;
          else in_frame = remaining > 32 ? 13'd32 : remaining;
          r = shift_out(FL_DUMMY, in_frame == 1, PH_DATA);
        end
      end
      PH_DATA: begin
        if (seq_op == OP_READ) begin
          remaining--;
          in_frame = remaining;
          if (remaining == 0) r = complete(ST_OK, 1'b1, rx);
          else r = mk(1'b1, FL_DUMMY, remaining == 1, 1'b1, rx, 1'b0, ST_OK);
        end else begin
          if (seq_op == OP_VERIFY && page_data[buf_pos[7:0]] != rx) frame_bad = 1'b1;
          buf_pos++;
          remaining--;
          in_frame--;
          if (seq_op == OP_PROG) begin
            if (in_frame > 0)
              r = shift_out(page_data[buf_pos[7:0]], in_frame == 1, PH_DATA);
            else r = begin_poll();
          end else if (in_frame > 0) r = shift_out(FL_DUMMY, in_frame == 1, PH_DATA);
          else if (frame_bad) r = complete(ST_CORRUPT, 1'b0, 8'h00);
          else if (remaining == 0) r = complete(ST_OK, 1'b0, 8'h00);
          else r = shift_out(FL_READ, 1'b0, PH_H1);
        end
      end
      default: got = 1'b0;
    endcase
  endtask

  // one accepted input word
  task automatic predict_word(input logic [2:0] cmd, input logic [9:0] blk,
                              input logic [11:0] off, input logic [12:0] len,
                              input logic [7:0] dat, output bit got, output res_t r);
    logic [15:0] lim;
    got = 1'b0;
    case (cmd)
      CMD_READ, CMD_PROG, CMD_ERASE: begin
        if (seq_phase == PH_IDLE) begin
          got = 1'b1;
          buf_pos = '0;
          frame_bad = 1'b0;
          if (cmd == CMD_ERASE) begin
            seq_op = OP_ERASE;
            base_addr = {2'b00, blk, 12'h000};
            remaining = 13'd1;
            r = begin_poll();
          end else if (len == 0 || (cmd == CMD_PROG && len > 256)) begin
            r = complete(ST_INVALID, 1'b0, 8'h00);
          end else begin
            seq_op = (cmd == CMD_READ) ? OP_READ : OP_PROG;
            base_addr = {2'b00, blk, off};
            remaining = len;
            if (cmd == CMD_READ) r = begin_poll();
            else begin
              seq_phase = PH_COLLECT;
              got = 1'b0;
            end
          end
        end
      end
      CMD_DATA: begin
        if (seq_phase == PH_COLLECT) begin
          page_data[buf_pos[7:0]] = dat;
          buf_pos++;
          if (13'(buf_pos) >= remaining) begin
            buf_pos = '0;
            got = 1'b1;
            r = begin_poll();
          end
        end
      end
      CMD_RX: take_rx(dat, got, r);
      CMD_TICK: begin
        lim = (seq_op == OP_READ) ? rd_limit : wr_limit;
        if (seq_phase inside {PH_POLL_CMD, PH_POLL_STAT, PH_POLL_TICK}) begin
          if (ticks_seen != 16'hFFFF) ticks_seen++;
          if (seq_phase == PH_POLL_TICK) begin
            got = 1'b1;
            if (ticks_seen >= lim) r = complete(ST_IO, 1'b0, 8'h00);
            else r = shift_out(FL_RDSR, 1'b0, PH_POLL_CMD);
          end
        end
      end
      default: ;
    endcase
  endtask

  // track, predict and compare at each edge
  always @(posedge clk) begin
    bit   got;
    res_t r, e;
    if (!rst_n) begin
      rd_limit <= ReadWaitRst; wr_limit <= WriteWaitRst;
      seq_phase = PH_IDLE; seq_op = OP_READ; base_addr = '0; remaining = '0;
      in_frame = '0; buf_pos = '0; ticks_seen = '0; frame_bad = 1'b0;
      expected_words.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_READ_WAIT) rd_limit <= cfg_wdata;
        else wr_limit <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        predict_word(in_cmd, in_block_index, in_offset, in_length, in_data_byte, got, r);
        if (got) expected_words.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation waiting");
          errors <= errors + 1;
        end else begin
          e = expected_words.pop_front();
          r = mk(out_tx_valid, out_tx_byte, out_cs_release, out_rd_valid, out_rd_byte,
                 out_done_res, out_status);
          if (r != e) errors <= errors + 1;
          if (r.tx_valid != e.tx_valid)
            $error("tx_valid exp %0h act %0h", e.tx_valid, r.tx_valid);
          if (r.tx_byte != e.tx_byte)
            $error("tx_byte exp %0h act %0h", e.tx_byte, r.tx_byte);
          if (r.cs_release != e.cs_release)
            $error("cs_release exp %0h act %0h", e.cs_release, r.cs_release);
          if (r.rd_valid != e.rd_valid)
            $error("rd_valid exp %0h act %0h", e.rd_valid, r.rd_valid);
          if (r.rd_byte != e.rd_byte)
            $error("rd_byte exp %0h act %0h", e.rd_byte, r.rd_byte);
          if (r.done_res != e.done_res)
            $error("done_res exp %0h act %0h", e.done_res, r.done_res);
          if (r.status != e.status)
            $error("status exp %0h act %0h", e.status, r.status);
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

// ===== sim/spi_flash_command_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_tb
// drives request, data, spi and tick words with random gaps and stalls
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_tb;
  import sfcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid, in_ready;
  logic [2:0]  in_cmd;
  logic [9:0]  in_block_index;
  logic [11:0] in_offset;
  logic [12:0] in_length;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_ready;
  logic        out_tx_valid, out_cs_release, out_rd_valid, out_done_res;
  logic [7:0]  out_tx_byte, out_rd_byte;
  logic [1:0]  out_status;
  int          errors, pending;

  bit burst;      // no gaps on either side
  bit hold_req;   // ask the receiver for a long stall
  int words_sent;
  longint cycles;

  spi_flash_command_sequencer i_dut (.*);

  spi_flash_command_sequencer_checker i_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3_000_000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side: random stalls and one long hold-off
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      w = burst ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic put_word(logic [2:0] cmd, logic [9:0] blk, logic [11:0] off,
                          logic [12:0] len, logic [7:0] dat);
    int g;
    g = burst ? 0 : $urandom_range(0, 14);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_cmd <= cmd; in_block_index <= blk; in_offset <= off;
    in_length <= len; in_data_byte <= dat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // drain all expected words, then allow for the block's latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one request with its data and a plausible flash answer stream;
  // a clean flash answers every byte with one value that is ready, has wel set
  // and equals the written data, a noisy flash answers at random
  task automatic run_request(logic [2:0] cmd, logic [9:0] blk, logic [11:0] off,
                             logic [12:0] len, bit clean);
    logic [7:0] c;
    int n;
    c = {6'($urandom), 2'b10};
    put_word(cmd, blk, off, len, 8'($urandom));
    if (cmd == CMD_PROG)
      for (int i = 0; i < ((len > 300) ? 300 : len); i++)
        put_word(CMD_DATA, 10'($urandom), 12'($urandom), 13'($urandom),
                 clean ? c : 8'($urandom));
    n = (cmd == CMD_ERASE) ? 40 : (cmd == CMD_READ) ? int'(len) + 40 : 2 * len + 40;
    for (int i = 0; i < n; i++) begin
      if (clean) begin
        if ($urandom_range(0, 15) == 0) put_word(CMD_TICK, '0, '0, '0, 8'($urandom));
        else put_word(CMD_RX, 10'($urandom), 12'($urandom), 13'($urandom), c);
      end else begin
        if ($urandom_range(0, 3) == 0) put_word(CMD_TICK, '0, '0, '0, 8'($urandom));
        else put_word(CMD_RX, '0, '0, '0, 8'($urandom));
      end
    end
  endtask

  task automatic random_request();
    logic [2:0]  cmd;
    logic [12:0] len;
    cmd = 3'($urandom_range(0, 2));
    len = ($urandom_range(0, 19) == 0) ? 13'($urandom_range(0, 72))
                                       : 13'($urandom_range(1, 24));
    if ($urandom_range(0, 9) == 0)
      put_word(3'($urandom), 10'($urandom), 12'($urandom), 13'($urandom), 8'($urandom));
    else
      run_request(cmd, 10'($urandom), 12'($urandom), len, $urandom_range(0, 9) < 7);
  endtask

  // stimulus and verdict
  initial begin
    logic [15:0] rd_set [4];
    logic [15:0] wr_set [4];
    rd_set = '{16'd1, 16'd65535, 16'd2, 16'd0};
    wr_set = '{16'd1, 16'd65535, 16'd4, 16'd0};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = CFG_READ_WAIT; cfg_wdata = '0;
    in_valid = 1'b0; in_cmd = CMD_TICK; in_block_index = '0; in_offset = '0;
    in_length = '0; in_data_byte = '0;
    burst = 1'b0; hold_req = 1'b0; words_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, invalid lengths, page crossing, ignored words
    run_request(CMD_READ, 10'd1023, 12'd4095, 13'd1, 1'b1);
    put_word(CMD_READ, 10'd5, 12'd7, 13'd0, 8'h00);
    put_word(CMD_PROG, 10'd5, 12'd7, 13'd0, 8'h00);
    put_word(CMD_PROG, 10'd5, 12'd7, 13'd257, 8'h00);
    run_request(CMD_PROG, 10'd0, 12'd255, 13'd2, 1'b1);
    run_request(CMD_PROG, 10'd1023, 12'd0, 13'd40, 1'b1);
    run_request(CMD_ERASE, 10'd1023, 12'd4095, 13'd8191, 1'b1);
    run_request(CMD_PROG, 10'd3, 12'd40, 13'd3, 1'b0);
    put_word(3'd6, 10'd1023, 12'd4095, 13'd8191, 8'hFF);
    put_word(3'd7, 10'd0, 12'd0, 13'd0, 8'h00);
    put_word(CMD_DATA, '0, '0, '0, 8'hA5);
    put_word(CMD_TICK, '0, '0, '0, 8'h00);
    drain();

    // busy timeout on a read, then wel clear on an erase
    write_reg(CFG_READ_WAIT, 16'd1);
    put_word(CMD_READ, 10'd9, 12'd9, 13'd4, 8'h00);
    put_word(CMD_RX, '0, '0, '0, 8'h00);
    put_word(CMD_RX, '0, '0, '0, 8'h01);
    put_word(CMD_TICK, '0, '0, '0, 8'h00);
    put_word(CMD_ERASE, 10'd9, 12'd0, 13'd0, 8'h00);
    put_word(CMD_RX, '0, '0, '0, 8'h00);
    put_word(CMD_RX, '0, '0, '0, 8'h00);
    for (int i = 0; i < 4; i++) put_word(CMD_RX, '0, '0, '0, 8'h00);
    drain();

    // random phases over several register settings
    for (int p = 0; p < 4; p++) begin
      if (p == 3) begin
        rd_set[3] = 16'($urandom_range(1, 20));
        wr_set[3] = 16'($urandom_range(1, 20));
      end
      write_reg(CFG_READ_WAIT, rd_set[p]);
      write_reg(CFG_WRITE_WAIT, wr_set[p]);
      if (p == 1) hold_req = 1'b1;
      while (words_sent < 360 + 190 * (p + 1)) begin
        burst = ($urandom_range(0, 5) == 0);
        random_request();
      end
      burst = 1'b0;
      drain();
    end

    // one long read without gaps
    burst = 1'b1;
    run_request(CMD_READ, 10'($urandom), 12'd0, 13'd64, 1'b1);
    burst = 1'b0;
    drain();

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
